FILE: src/fire_spread_life_stencil_assert.svh
// ============================================================================
// fire_spread_life_stencil assertion macros
// Concurrent property wrappers; they expand to nothing when SYNTH is defined.
// ============================================================================
`ifndef FIRE_SPREAD_LIFE_STENCIL_ASSERT_SVH
`define FIRE_SPREAD_LIFE_STENCIL_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FSLS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fire_spread_life_stencil: same-cycle property failed");
// next-cycle implication
`define FSLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fire_spread_life_stencil: next-cycle property failed");
`else
`define FSLS_ASSERT_SAME(label, clk, rst, ante, cons)
`define FSLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/fsls_pkg.sv
// ============================================================================
// fsls_pkg
// Shared types and constants of the fire spread stencil.
// ============================================================================
package fsls_pkg;

   // register file
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 13;
   localparam int GRID_WIDTH_BITS  = 6;
   localparam int GRID_HEIGHT_BITS = 13;
   localparam int CODE_BITS        = 8;
   localparam int ROW_BITS         = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOUSE_CODE   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURNING_CODE = 2'd3;

   localparam logic [GRID_WIDTH_BITS-1:0]  RESET_GRID_WIDTH   = 6'd62;
   localparam logic [GRID_HEIGHT_BITS-1:0] RESET_GRID_HEIGHT  = 13'd62;
   localparam logic [CODE_BITS-1:0]        RESET_HOUSE_CODE   = 8'd1;
   localparam logic [CODE_BITS-1:0]        RESET_BURNING_CODE = 8'd2;
   localparam logic [GRID_HEIGHT_BITS-1:0] MAX_HEIGHT         = 13'd4096;

   // what the stage register in front of the window holds
   localparam logic [1:0] KIND_ITEM  = 2'd0;  // an input tile with its column
   localparam logic [1:0] KIND_FLUSH = 2'd1;  // one column of the last row
   localparam logic [1:0] KIND_FINAL = 2'd2;  // closing cell of the frame

   // burning flags of one window column
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } col_flags_type;

   // 3x3 window with per-column in-grid qualifiers
   typedef struct packed {
      col_flags_type left;
      col_flags_type center;
      col_flags_type right;
      logic          left_ok;
      logic          center_ok;
      logic          right_ok;
   } window_type;

endpackage

FILE: src/fsls_rule.sv
// ============================================================================
// fsls_rule
// Neighbor count and next-generation rule for the center cell of a window.
// ============================================================================
module fsls_rule
   import fsls_pkg::*;
#(
   parameter int TILE_BITS = 8
)
(
   input  window_type           win_i,
   input  logic [TILE_BITS-1:0] self_tile_i,
   input  logic [TILE_BITS-1:0] house_tile_i,
   input  logic [TILE_BITS-1:0] burn_tile_i,
   output logic [TILE_BITS-1:0] next_tile_o
);

   logic       self_burn;
   logic [4:0] hits;
   logic [4:0] nbr;
   logic       ignite;
   logic       dies;

   assign self_burn = win_i.center.mid;

   // all nine positions, then take the center tile back out
   assign hits = 5'(win_i.left.top   & win_i.left_ok)
               + 5'(win_i.left.mid   & win_i.left_ok)
               + 5'(win_i.left.bot   & win_i.left_ok)
               + 5'(win_i.center.top & win_i.center_ok)
               + 5'(win_i.center.mid & win_i.center_ok)
               + 5'(win_i.center.bot & win_i.center_ok)
               + 5'(win_i.right.top  & win_i.right_ok)
               + 5'(win_i.right.mid  & win_i.right_ok)
               + 5'(win_i.right.bot  & win_i.right_ok);

   // wraps to all ones when an uncounted burning center is removed: counts as many
   assign nbr = hits - 5'(self_burn);

   assign ignite = (nbr == 5'd3) && (self_tile_i == house_tile_i);
   assign dies   = self_burn && (nbr != 5'd2) && (nbr != 5'd3);

   // ignition wins when the two codes are equal
   always_comb begin
      if (ignite) begin
         next_tile_o = burn_tile_i;
      end else if (dies) begin
         next_tile_o = house_tile_i;
      end else begin
         next_tile_o = self_tile_i;
      end
   end

endmodule

FILE: src/fire_spread_life_stencil.sv
// ============================================================================
// fire_spread_life_stencil
// One generation of a burning-house cellular automaton over a raster tile grid.
// ============================================================================
//
//   channel | direction | handshake            | beat carries
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_stall  | req_tile_in
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_tile_out, rsp_frame_last
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One tile per cycle unless req_stall; results leave through the stage and
// result registers. The tile that ends a row holds the input for a second
// evaluation (two results share the window evaluator). The tile that ends a
// frame flushes the last row out of the line store, one column per cycle
// unless rsp_stall holds it. Reset clears counters, handshakes and configuration;
// the line store is not cleared. rsp_stall freezes the result register and
// backs up into req_stall.
`include "fire_spread_life_stencil_assert.svh"

module fire_spread_life_stencil
   import fsls_pkg::*;
#(
   parameter int MAX_WIDTH = 62,
   parameter int TILE_BITS = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [TILE_BITS-1:0]      req_tile_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [TILE_BITS-1:0]      rsp_tile_out,
   output logic                      rsp_frame_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int COL_BITS  = $clog2(MAX_WIDTH + 1);
   localparam logic [COL_BITS-1:0] MAX_COL = COL_BITS'(MAX_WIDTH);

   // line store entry: row above the incoming one and the row above that
   typedef struct packed {
      logic [TILE_BITS-1:0] newer;
      logic [TILE_BITS-1:0] older;
   } line_entry_type;

   // configuration
   logic [GRID_WIDTH_BITS-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_BITS-1:0] grid_height_ff;
   logic [CODE_BITS-1:0]        house_code_ff;
   logic [CODE_BITS-1:0]        burning_code_ff;
   logic [COL_BITS-1:0]         w_eff;
   logic [COL_BITS-1:0]         w_last;
   logic [GRID_HEIGHT_BITS-1:0] h_eff;
   logic [GRID_HEIGHT_BITS-1:0] h_last;
   logic [TILE_BITS-1:0]        house_tile;
   logic [TILE_BITS-1:0]        burn_tile;

   // input position
   logic [ADDR_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic                 in_end_row;
   logic                 in_end_frame;
   logic                 in_acc;

   // line store
   line_entry_type       line_mem [MAX_WIDTH];
   line_entry_type       rd_ff;
   line_entry_type       wr_data;
   logic                 rd_en;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ADDR_BITS-1:0] wr_addr;

   // stage register in front of the window
   logic                 s1_valid_ff;
   logic [1:0]           s1_kind_ff;
   logic [ADDR_BITS-1:0] s1_col_ff;
   logic [TILE_BITS-1:0] s1_tile_ff;
   logic                 s1_row1_ff;
   logic                 s1_row2_ff;
   logic                 s1_end_row_ff;
   logic                 s1_end_frame_ff;
   logic                 s1_phase_ff;
   logic                 s1_free;
   logic                 s1_hold_frame;

   // last-row flush
   logic                flush_ff;
   logic [COL_BITS-1:0] fl_idx_ff;
   logic                fl_above_ff;
   logic                fl_load;
   logic                fl_final;

   // window and evaluation
   col_flags_type        wa_ff;
   col_flags_type        wb_ff;
   logic [TILE_BITS-1:0] wb_tile_ff;
   col_flags_type        new_col;
   logic [TILE_BITS-1:0] new_tile;
   logic [ADDR_BITS-1:0] ev_center;
   logic [COL_BITS-1:0]  ev_center_w;
   logic                 ev_emit;
   logic                 ev_last;
   logic                 ev_go;
   logic                 ev_done;
   logic [TILE_BITS-1:0] ev_tile;
   window_type           win;

   // result register
   logic                 rsp_valid_ff;
   logic [TILE_BITS-1:0] rsp_tile_ff;
   logic                 rsp_last_ff;
   logic                 out_free;

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= RESET_GRID_WIDTH;
         grid_height_ff  <= RESET_GRID_HEIGHT;
         house_code_ff   <= RESET_HOUSE_CODE;
         burning_code_ff <= RESET_BURNING_CODE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[GRID_WIDTH_BITS-1:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[GRID_HEIGHT_BITS-1:0];
            CSR_HOUSE_CODE:   house_code_ff   <= csr_wdata[CODE_BITS-1:0];
            CSR_BURNING_CODE: burning_code_ff <= csr_wdata[CODE_BITS-1:0];
         endcase
      end
   end

   // clamp width and height into their legal ranges
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = COL_BITS'(1);
      end else if (int'(grid_width_ff) > MAX_WIDTH) begin
         w_eff = MAX_COL;
      end else begin
         w_eff = COL_BITS'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         h_eff = GRID_HEIGHT_BITS'(1);
      end else if (grid_height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = grid_height_ff;
      end
   end

   assign w_last     = w_eff - COL_BITS'(1);
   assign h_last     = h_eff - GRID_HEIGHT_BITS'(1);
   assign house_tile = TILE_BITS'(house_code_ff);
   assign burn_tile  = TILE_BITS'(burning_code_ff);

   // ---------------------------------------------------------- input position
   assign in_end_row   = COL_BITS'(col_ff) >= w_last;
   assign in_end_frame = in_end_row && (GRID_HEIGHT_BITS'(row_ff) >= h_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_acc) begin
         if (in_end_frame) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (in_end_row) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_BITS'(1);
         end else begin
            col_ff <= col_ff + ADDR_BITS'(1);
         end
      end
   end

   // -------------------------------------------------------------- handshakes
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign ev_go         = s1_valid_ff && (!ev_emit || out_free);
   assign ev_done       = ev_go && !(s1_kind_ff == KIND_ITEM && s1_end_row_ff && !s1_phase_ff);
   assign s1_free       = !s1_valid_ff || ev_done;
   assign s1_hold_frame = s1_valid_ff && (s1_kind_ff == KIND_ITEM) && s1_end_frame_ff;
   assign req_stall     = flush_ff || s1_hold_frame || !s1_free;
   assign in_acc        = req_valid && !req_stall;
   assign fl_load       = flush_ff && s1_free;
   assign fl_final      = fl_idx_ff == w_eff;

   // -------------------------------------------------------------- line store
   // an item reads its column on the beat it is taken and writes it back
   // (shifted down one row) when it leaves the stage register
   assign rd_en   = in_acc || (fl_load && !fl_final);
   assign rd_addr = flush_ff ? fl_idx_ff[ADDR_BITS-1:0] : col_ff;
   assign wr_en   = ev_done && (s1_kind_ff == KIND_ITEM);
   assign wr_addr = s1_col_ff;
   assign wr_data = '{newer: s1_tile_ff, older: rd_ff.newer};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // same column written on this edge: forward it
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= line_mem[rd_addr];
         end
      end
   end

   // ---------------------------------------------------------- stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_phase_ff <= 1'b0;
      end else if (in_acc || fl_load) begin
         s1_valid_ff <= 1'b1;
         s1_phase_ff <= 1'b0;
      end else if (ev_done) begin
         s1_valid_ff <= 1'b0;
      end else if (ev_go) begin
         s1_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_kind_ff      <= KIND_ITEM;
         s1_col_ff       <= col_ff;
         s1_tile_ff      <= req_tile_in;
         s1_row1_ff      <= row_ff != '0;
         s1_row2_ff      <= row_ff >= ROW_BITS'(2);
         s1_end_row_ff   <= in_end_row;
         s1_end_frame_ff <= in_end_frame;
      end else if (fl_load) begin
         s1_kind_ff      <= fl_final ? KIND_FINAL : KIND_FLUSH;
         s1_col_ff       <= fl_final ? w_last[ADDR_BITS-1:0] : fl_idx_ff[ADDR_BITS-1:0];
         s1_end_row_ff   <= 1'b0;
         s1_end_frame_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------- flush
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= 1'b0;
      end else if (ev_done && s1_hold_frame) begin
         flush_ff <= 1'b1;
      end else if (fl_load && fl_final) begin
         flush_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_done && s1_hold_frame) begin
         fl_idx_ff   <= '0;
         fl_above_ff <= s1_row1_ff;
      end else if (fl_load && !fl_final) begin
         fl_idx_ff <= fl_idx_ff + COL_BITS'(1);
      end
   end

   // ------------------------------------------------------- column into window
   // streaming: rows r-2, r-1, r; flush: rows r-1, r and nothing below
   always_comb begin
      new_col   = '0;
      new_tile  = '0;
      ev_center = '0;
      ev_emit   = 1'b0;
      ev_last   = 1'b0;
      case (s1_kind_ff)
         KIND_ITEM: begin
            if (!s1_phase_ff) begin
               new_col.top = s1_row2_ff && (rd_ff.older == burn_tile);
               new_col.mid = rd_ff.newer == burn_tile;
               new_col.bot = s1_tile_ff == burn_tile;
               new_tile    = rd_ff.newer;
               ev_center   = s1_col_ff - ADDR_BITS'(1);
               ev_emit     = s1_row1_ff && (s1_col_ff != '0);
            end else begin
               // row end: closing cell with an empty column on its right
               ev_center = s1_col_ff;
               ev_emit   = s1_row1_ff;
            end
         end
         KIND_FLUSH: begin
            new_col.top = fl_above_ff && (rd_ff.older == burn_tile);
            new_col.mid = rd_ff.newer == burn_tile;
            new_tile    = rd_ff.newer;
            ev_center   = s1_col_ff - ADDR_BITS'(1);
            ev_emit     = s1_col_ff != '0;
         end
         KIND_FINAL: begin
            ev_center = s1_col_ff;
            ev_emit   = 1'b1;
            ev_last   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // columns outside the grid count as not burning
   assign ev_center_w   = COL_BITS'(ev_center);
   assign win.left      = wa_ff;
   assign win.center    = wb_ff;
   assign win.right     = new_col;
   assign win.left_ok   = (ev_center_w != '0) && ((ev_center_w - COL_BITS'(1)) < w_eff);
   assign win.center_ok = ev_center_w < w_eff;
   assign win.right_ok  = (ev_center_w + COL_BITS'(1)) < w_eff;

   always_ff @(posedge clock) begin
      if (ev_go) begin
         wa_ff      <= wb_ff;
         wb_ff      <= new_col;
         wb_tile_ff <= new_tile;
      end
   end

   fsls_rule #(
      .TILE_BITS (TILE_BITS)
   ) u_rule (
      .win_i        (win),
      .self_tile_i  (wb_tile_ff),
      .house_tile_i (house_tile),
      .burn_tile_i  (burn_tile),
      .next_tile_o  (ev_tile)
   );

   // --------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_go && ev_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_go && ev_emit) begin
         rsp_tile_ff <= ev_tile;
         rsp_last_ff <= ev_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_out   = rsp_tile_ff;
   assign rsp_frame_last = rsp_last_ff;

   // -------------------------------------------------------------- assertions
   // a held result is never overwritten by a new cell
   `FSLS_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !(ev_go && ev_emit))
   // the flush column index stays within the row
   `FSLS_ASSERT_SAME(a_flush_in_row, clock, reset, flush_ff, fl_idx_ff <= w_eff)
   // once the frame's last tile leaves the stage register the flush runs, input held
   `FSLS_ASSERT_NEXT(a_flush_starts, clock, reset, ev_done && s1_hold_frame, flush_ff && req_stall)

endmodule

FILE: tb/fire_spread_life_stencil_test.sv
`timescale 1ns / 100ps
// ============================================================================
// fire_spread_life_stencil_test
// Self-checking bench for the fire spread stencil. Tile frames go in through
// the req channel with random gaps; a tracker works out each next-generation
// tile from its own line stores and checks the rsp beats in order. Grid size
// and tile codes are reprogrammed between frames, extremes included.
// ============================================================================
module fire_spread_life_stencil_test;
   import fsls_pkg::*;

   localparam int MAX_COLUMNS  = 62;
   localparam int DRAIN_CYCLES = MAX_COLUMNS + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_TILES = 170;
   localparam int LIMIT_CYCLES = 1000000;

   // rows kept by the tracker
   localparam int OLDER    = 0;
   localparam int RECENT   = 1;
   localparam int INCOMING = 2;

   typedef struct packed {
      logic [CODE_BITS-1:0] tile;
      logic                 frame_end;
   } tile_beat_type;

   // next-generation tracker: grid settings, line stores and pending tiles
   class generation_tracker;
      logic [GRID_WIDTH_BITS-1:0]  grid_width;
      logic [GRID_HEIGHT_BITS-1:0] grid_height;
      logic [CODE_BITS-1:0]        house_code;
      logic [CODE_BITS-1:0]        burning_code;
      logic [CODE_BITS-1:0]        lines [3][MAX_COLUMNS];
      logic [ROW_BITS-1:0]         row_at;
      logic [GRID_WIDTH_BITS-1:0]  col_at;
      tile_beat_type               next_tiles[$];
      int                          errors;

      function new();
         grid_width   = RESET_GRID_WIDTH;
         grid_height  = RESET_GRID_HEIGHT;
         house_code   = RESET_HOUSE_CODE;
         burning_code = RESET_BURNING_CODE;
         foreach (lines[i, j]) lines[i][j] = '0;
         row_at = '0;
         col_at = '0;
         errors = 0;
      endfunction

      function void set_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_GRID_WIDTH:   grid_width   = value[GRID_WIDTH_BITS-1:0];
            CSR_GRID_HEIGHT:  grid_height  = value[GRID_HEIGHT_BITS-1:0];
            CSR_HOUSE_CODE:   house_code   = value[CODE_BITS-1:0];
            CSR_BURNING_CODE: burning_code = value[CODE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, oversize values clamp
      function int width_used();
         if (grid_width == 0) return 1;
         if (grid_width > MAX_COLUMNS) return MAX_COLUMNS;
         return grid_width;
      endfunction

      function int height_used();
         if (grid_height == 0) return 1;
         if (grid_height > MAX_HEIGHT) return MAX_HEIGHT;
         return grid_height;
      endfunction

      function int pending();
         return next_tiles.size();
      endfunction

      function int is_burning(input int sel, input int j, input int w);
         return (j >= 0 && j < w && lines[sel][j] == burning_code) ? 1 : 0;
      endfunction

      // ignition is tested before burn-out, so equal codes favor ignition
      function logic [CODE_BITS-1:0] next_state(input int above, input bit has_above,
                                                input int middle, input int below,
                                                input bit has_below, input int j,
                                                input int w);
         int                   n;
         int                   dj;
         logic [CODE_BITS-1:0] center_tile;
         n = 0;
         center_tile = lines[middle][j];
         for (dj = -1; dj <= 1; dj++) begin
            if (has_above) n += is_burning(above, j + dj, w);
            if (has_below) n += is_burning(below, j + dj, w);
            n += is_burning(middle, j + dj, w);
         end
         if (center_tile == burning_code) n--;
         if (n == 3 && center_tile == house_code) return burning_code;
         if ((n < 2 || n > 3) && center_tile == burning_code) return house_code;
         return center_tile;
      endfunction

      function void push_tile(input logic [CODE_BITS-1:0] tile, input bit frame_end);
         tile_beat_type beat;
         beat.tile = tile;
         beat.frame_end = frame_end;
         next_tiles.push_back(beat);
      endfunction

      // one accepted input beat
      function void take_tile(input logic [CODE_BITS-1:0] tile);
         int w;
         int h;
         int c;
         int r;
         bit end_row;
         bit end_frame;
         w = width_used();
         h = height_used();
         c = col_at;
         r = row_at;
         end_row = c >= w - 1;
         end_frame = end_row && r >= h - 1;
         lines[INCOMING][c] = tile;

         // cells of the row above whose window is now complete
         if (r >= 1) begin
            if (c >= 1)
               push_tile(next_state(OLDER, r >= 2, RECENT, INCOMING, 1'b1, c - 1, w), 1'b0);
            if (end_row)
               push_tile(next_state(OLDER, r >= 2, RECENT, INCOMING, 1'b1, c, w), 1'b0);
         end

         if (end_frame) begin
            // flush the last row, nothing below it
            for (int j = 0; j < w; j++)
               push_tile(next_state(RECENT, r >= 1, INCOMING, INCOMING, 1'b0, j, w),
                         j == w - 1);
            row_at = '0;
            col_at = '0;
         end else if (end_row) begin
            lines[OLDER] = lines[RECENT];
            lines[RECENT] = lines[INCOMING];
            col_at = '0;
            row_at = r + 1;
         end else begin
            col_at = c + 1;
         end
      endfunction

      // one accepted result beat against the oldest expectation
      function void match_tile(input logic [CODE_BITS-1:0] tile, input logic frame_end);
         tile_beat_type want;
         if (next_tiles.size() == 0) begin
            $error("unexpected result: rsp_tile_out=%0h rsp_frame_last=%0b",
                   tile, frame_end);
            errors++;
            return;
         end
         want = next_tiles.pop_front();
         if (tile !== want.tile) begin
            $error("rsp_tile_out: expected %0h, actual %0h", want.tile, tile);
            errors++;
         end
         if (frame_end !== want.frame_end) begin
            $error("rsp_frame_last: expected %0b, actual %0b", want.frame_end, frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [CODE_BITS-1:0]      req_tile_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CODE_BITS-1:0]      rsp_tile_out;
   logic                      rsp_frame_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   generation_tracker tracker;
   bit                burst;              // sender offers with no gaps
   bit                drain_request;      // sender waits for every result
   bit                hold_rsp_request;   // receiver holds off for a long stretch
   int                cycle_count;

   fire_spread_life_stencil DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tile_in    (req_tile_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_out   (rsp_tile_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one register beat; csr_valid stays high for the caller to drop
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.set_reg(index, value);
   endtask

   // unused upper data bits carry random noise
   task automatic program_grid(input int w_raw, input int h_raw,
                               input int house, input int burn);
      write_reg(CSR_GRID_WIDTH, ($urandom_range(0, 127) << GRID_WIDTH_BITS) | w_raw);
      write_reg(CSR_GRID_HEIGHT, h_raw);
      write_reg(CSR_HOUSE_CODE, ($urandom_range(0, 31) << CODE_BITS) | house);
      write_reg(CSR_BURNING_CODE, ($urandom_range(0, 31) << CODE_BITS) | burn);
      csr_valid <= 1'b0;
   endtask

   // quiet the input and let the block drain before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_tile(input logic [CODE_BITS-1:0] tile);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (drain_request && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain_request && tracker.pending() != 0) @(posedge clock);
         drain_request = 1'b0;
      end
      req_valid   <= 1'b1;
      req_tile_in <= tile;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_tile(tile);
   endtask

   // mostly houses and fires, some stray codes
   function automatic logic [CODE_BITS-1:0] pick_tile();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return tracker.house_code;
      if (roll < 75) return tracker.burning_code;
      return $urandom_range(0, 255);
   endfunction

   task automatic send_frame();
      int frame_tiles;
      frame_tiles = tracker.width_used() * tracker.height_used();
      repeat (frame_tiles) send_tile(pick_tile());
   endtask

   // stimulus
   initial begin
      logic [CODE_BITS-1:0] pattern[$];
      int                   random_tiles;
      int                   frame_tiles;
      int                   w_raw;
      int                   h_raw;
      int                   house;
      int                   burn;
      bit                   first_drain;

      reset = 1'b1;
      req_valid = 1'b0;
      req_tile_in = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      burst = 1'b0;
      drain_request = 1'b0;
      hold_rsp_request = 1'b0;
      tracker = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // blinker: survival, burn-out and ignition, stray codes pass through
      settle();
      program_grid(3, 3, 8'h01, 8'h02);
      pattern = '{8'h00, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01, 8'h02, 8'hFF};
      foreach (pattern[k]) send_tile(pattern[k]);

      // zero width and height act as one; lone fire burns out
      settle();
      program_grid(0, 0, 8'hFF, 8'h00);
      send_tile(8'h00);

      // equal house and burning codes
      settle();
      program_grid(2, 2, 8'h5A, 8'h5A);
      pattern = '{8'h5A, 8'h5A, 8'h5A, 8'h5A};
      foreach (pattern[k]) send_tile(pattern[k]);

      // crowded fires burn out, a house with five burning neighbours does not ignite
      settle();
      program_grid(4, 2, 8'hA5, 8'h3C);
      pattern = '{8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'hA5, 8'h3C};
      foreach (pattern[k]) send_tile(pattern[k]);

      // oversize width clamps; receiver holds off so the block backs up
      settle();
      program_grid(63, 2, $urandom_range(0, 255), $urandom_range(0, 255));
      burst = 1'b1;
      hold_rsp_request = 1'b1;
      send_frame();
      burst = 1'b0;

      // tallest frame, single column: row counter runs to its end
      settle();
      program_grid(1, 8191, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame();

      // random grids and codes, mostly small
      random_tiles = 0;
      first_drain = 1'b1;
      while (random_tiles < RANDOM_TILES) begin
         w_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
         h_raw = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
         if (w_raw > 20 && h_raw > 2) h_raw = 2;
         house = $urandom_range(0, 255);
         burn = ($urandom_range(0, 7) == 0) ? house : $urandom_range(0, 255);
         settle();
         program_grid(w_raw, h_raw, house, burn);
         burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 2)) begin
            frame_tiles = tracker.width_used() * tracker.height_used();
            for (int i = 0; i < frame_tiles; i++) begin
               // once, pause mid-frame until the block has caught up
               if (first_drain && i == frame_tiles / 2) begin
                  drain_request = 1'b1;
                  first_drain = 1'b0;
               end
               send_tile(pick_tile());
               random_tiles++;
            end
         end
         burst = 1'b0;
      end

      settle();
      if (tracker.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // result side: random stalls, quiet stretches, one long hold-off
   initial begin
      int stall_cycles;
      int quiet_run;
      rsp_stall = 1'b0;
      quiet_run = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_cycles = HOLD_CYCLES;
         end else if (quiet_run > 0) begin
            quiet_run--;
            stall_cycles = 0;
         end else begin
            stall_cycles = $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0) quiet_run = $urandom_range(20, 60);
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.match_tile(rsp_tile_out, rsp_frame_last);
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
